// ===== rtl/vwbp_pkg.sv =====
// ============================================================================
// vwbp_pkg: shared types and constants of the variable width bit packer
// Holds the queue entry layout, status groups and the width clamp function.
// ============================================================================
package vwbp_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int FB_W       = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = 3;

  // Largest usable width: the smaller of MAX_WIDTH and the value width.
  localparam int EFF_MAX = (MAX_WIDTH < VALUE_W) ? MAX_WIDTH : VALUE_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);
  localparam logic [FB_W-1:0]  FB_EMPTY  = FB_W'(BYTE_W);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CFG_W-1:0]   width;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } fifo_status_t;

  typedef struct packed {
    logic            busy;
    logic [FB_W-1:0] free_bits;
    logic            final_emit;
  } back_status_t;

  // Clamp the configured width into 1..EFF_MAX.
  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] fw);
    logic [CFG_W-1:0] w;
    w = fw;
    if (w == '0) begin
      w = CFG_W'(1);
    end
    if (int'(w) > EFF_MAX) begin
      w = CFG_W'(EFF_MAX);
    end
    return w;
  endfunction

endpackage

// ===== rtl/vwbp_front.sv =====
// ============================================================================
// vwbp_front: input side of the bit packer
// Holds the width register, clamps the width, masks each value and queues it.
// ============================================================================
module vwbp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [vwbp_pkg::VALUE_W-1:0]    s_tdata,
  input  logic                            s_tlast,
  input  logic                            cfg_wr_en,
  input  logic [vwbp_pkg::CFG_W-1:0]      cfg_wr_data,
  input  vwbp_pkg::fifo_status_t          fifo_st,
  output logic                            push,
  output vwbp_pkg::item_t                 push_item
);

  logic [vwbp_pkg::CFG_W-1:0]   field_width;
  logic [vwbp_pkg::CFG_W-1:0]   width_eff;
  logic [vwbp_pkg::VALUE_W-1:0] value_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= vwbp_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      field_width <= cfg_wr_data;
    end
  end

  // A shift by the full value width yields zero, so the mask is all ones.
  assign width_eff  = vwbp_pkg::eff_width(field_width);
  assign value_mask = ~({vwbp_pkg::VALUE_W{1'b1}} << width_eff);

  assign s_tready = !fifo_st.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_item.value = s_tdata & value_mask;
    push_item.width = width_eff;
    push_item.last  = s_tlast;
  end

endmodule

// ===== rtl/vwbp_fifo.sv =====
// ============================================================================
// vwbp_fifo: short queue between front and back
// Holds masked items so either side may stall on its own.
// ============================================================================
module vwbp_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vwbp_pkg::item_t        push_item,
  input  logic                   pop,
  output vwbp_pkg::item_t        head_item,
  output vwbp_pkg::fifo_status_t status
);

  vwbp_pkg::item_t                entries [vwbp_pkg::FIFO_DEPTH];
  logic [vwbp_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [vwbp_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [vwbp_pkg::CNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head_item    = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == vwbp_pkg::CNT_W'(vwbp_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== rtl/vwbp_back.sv =====
// ============================================================================
// vwbp_back: byte assembly side of the bit packer
// Splits each queued value into byte chunks, at most one output byte per cycle when the output is free.
// ============================================================================
module vwbp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  vwbp_pkg::item_t               head_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vwbp_pkg::BYTE_W-1:0]   m_tdata,
  output logic                          m_tlast,
  output vwbp_pkg::back_status_t        status
);

  logic                          slot_valid;
  logic [vwbp_pkg::VALUE_W-1:0]  cur_v;
  logic [vwbp_pkg::CFG_W-1:0]    cur_w;
  logic                          cur_last;
  logic [vwbp_pkg::BYTE_W-1:0]   partial;
  logic [vwbp_pkg::FB_W-1:0]     fb;

  logic                          out_space;
  logic                          step;
  logic                          emit_full;
  logic [vwbp_pkg::CFG_W-1:0]    w_after;
  logic [vwbp_pkg::BYTE_W-1:0]   full_byte;
  logic [vwbp_pkg::BYTE_W-1:0]   tail_byte;
  logic [vwbp_pkg::FB_W-1:0]     tail_shift;

  logic                          emit;
  logic [vwbp_pkg::BYTE_W-1:0]   emit_byte;
  logic                          emit_final;
  logic                          done;
  logic [vwbp_pkg::VALUE_W-1:0]  cur_v_next;
  logic [vwbp_pkg::CFG_W-1:0]    cur_w_next;
  logic [vwbp_pkg::BYTE_W-1:0]   partial_next;
  logic [vwbp_pkg::FB_W-1:0]     fb_next;

  assign out_space = !m_tvalid || m_tready;
  assign step      = slot_valid && out_space;

  assign emit_full  = (cur_w >= {{(vwbp_pkg::CFG_W-vwbp_pkg::FB_W){1'b0}}, fb});
  assign w_after    = cur_w - {{(vwbp_pkg::CFG_W-vwbp_pkg::FB_W){1'b0}}, fb};
  assign full_byte  = partial | (cur_v[vwbp_pkg::BYTE_W-1:0] &
                                 ~({vwbp_pkg::BYTE_W{1'b1}} << fb));
  assign tail_shift = fb - cur_w[vwbp_pkg::FB_W-1:0];
  assign tail_byte  = partial | (cur_v[vwbp_pkg::BYTE_W-1:0] << tail_shift);

  always_comb begin
    emit         = 1'b0;
    emit_byte    = full_byte;
    emit_final   = 1'b0;
    done         = 1'b0;
    cur_v_next   = cur_v;
    cur_w_next   = cur_w;
    partial_next = partial;
    fb_next      = fb;
    if (emit_full) begin
      // Fill the free low bits and send the byte; the rest starts a new byte.
      emit         = 1'b1;
      emit_byte    = full_byte;
      emit_final   = cur_last && (w_after == '0);
      done         = (w_after == '0);
      cur_v_next   = cur_v >> fb;
      cur_w_next   = w_after;
      partial_next = '0;
      fb_next      = vwbp_pkg::FB_EMPTY;
    end else begin
      // Leftover bits sit at the top of the free part; flush on last.
      done = 1'b1;
      if (cur_last) begin
        emit         = 1'b1;
        emit_byte    = tail_byte;
        emit_final   = 1'b1;
        partial_next = '0;
        fb_next      = vwbp_pkg::FB_EMPTY;
      end else begin
        partial_next = tail_byte;
        fb_next      = tail_shift;
      end
    end
  end

  assign pop = head_valid && (!slot_valid || (step && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      partial    <= '0;
      fb         <= vwbp_pkg::FB_EMPTY;
      m_tvalid   <= 1'b0;
    end else begin
      if (step && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (step) begin
        partial <= partial_next;
        fb      <= fb_next;
      end
      if (pop) begin
        slot_valid <= 1'b1;
      end else if (step && done) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_v    <= head_item.value;
      cur_w    <= head_item.width;
      cur_last <= head_item.last;
    end else if (step) begin
      cur_v <= cur_v_next;
      cur_w <= cur_w_next;
    end
    if (step && emit) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_final;
    end
  end

  assign status.busy       = slot_valid;
  assign status.free_bits  = fb;
  assign status.final_emit = step && emit && emit_final;

endmodule

// ===== rtl/variable_width_bit_packer_top.sv =====
// ============================================================================
// variable_width_bit_packer_top: packs fixed-width values into a byte stream
// Front clamps and masks values, a short queue decouples, back emits bytes.
// ============================================================================
// Usage:
//   Slave stream (s_*) carries one value per transaction in s_tdata, with
//   s_tlast marking the final value of a stream. Master stream (m_*) carries
//   one packed byte per transaction; m_tlast flags the last byte of a stream.
//   Bytes fill from the top bit down; a value that overflows the free bits
//   continues, low chunk first, at the top of the following bytes.
//   cfg_wr_en/cfg_wr_data write the field width (0 acts as 1, above 32 acts
//   as 32); write it only while no transaction is in flight.
// Timing:
//   With an idle back end, an accepted value is written into the queue, then
//   into the back end's current-value register, then its first byte, if any,
//   into the output register. The back end handles one chunk per cycle while
//   the output is not stalled: one step per byte the value completes plus one
//   for leftover bits. Non-last values only adding to a partial byte give no
//   output. The four-entry queue absorbs input while the back end is busy.
// Reset and stall:
//   rst (synchronous) empties the queue, drops any partial byte and restores
//   width 8. A stalled receiver holds the output byte; the back end then
//   holds, the queue fills, and s_tready drops when it is full.
// ============================================================================
module variable_width_bit_packer_top (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: [31:0] value
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [vwbp_pkg::VALUE_W-1:0]  s_tdata,
  input  logic                          s_tlast,
  // m_tdata: [7:0] out_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vwbp_pkg::BYTE_W-1:0]   m_tdata,
  output logic                          m_tlast,
  input  logic                          cfg_wr_en,
  input  logic [vwbp_pkg::CFG_W-1:0]    cfg_wr_data
);

  logic                   push;
  vwbp_pkg::item_t        push_item;
  logic                   pop;
  vwbp_pkg::item_t        head_item;
  vwbp_pkg::fifo_status_t fifo_st;
  vwbp_pkg::back_status_t back_st;

  // Front: width register, clamp and mask, push into the queue.
  vwbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fifo_st     (fifo_st),
    .push        (push),
    .push_item   (push_item)
  );

  // Queue: lets front and back stall independently.
  vwbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (fifo_st)
  );

  // Back: split values into bytes and drive the output register.
  vwbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!fifo_st.empty),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .status     (back_st)
  );

  // Free bit count of the current byte always stays within one byte.
  a_free_bits_range: assert property (@(posedge clk) disable iff (rst)
    (back_st.free_bits >= 4'd1) && (back_st.free_bits <= 4'd8))
    else $error("free bit count out of range");

  // Queue never overfills.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_st.count <= vwbp_pkg::CNT_W'(vwbp_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  // After the final byte of a stream the next byte starts empty.
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    back_st.final_emit |=> (back_st.free_bits == vwbp_pkg::FB_EMPTY))
    else $error("partial byte not cleared after final byte");

  // Nothing is popped while the queue is empty.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_st.empty)
    else $error("pop from empty queue");

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb: self-checking bench for the variable width bit packer
// Streams values at many field widths through the packer, predicts every
// packed byte and its final-byte flag, and checks the output stream in order
// under random sender bursts and receiver stalls.
// ============================================================================
module tb;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 390;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_t;

  typedef struct packed {
    logic [vwbp_pkg::BYTE_W-1:0] data;
    logic                        last_flag;
  } packed_byte_t;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           s_tvalid    = 1'b0;
  logic                           s_tready;
  logic [vwbp_pkg::VALUE_W-1:0]   s_tdata     = '0;
  logic                           s_tlast     = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready    = 1'b0;
  logic [vwbp_pkg::BYTE_W-1:0]    m_tdata;
  logic                           m_tlast;
  logic                           cfg_wr_en   = 1'b0;
  logic [vwbp_pkg::CFG_W-1:0]     cfg_wr_data = '0;

  // Packer state as the bench sees it.
  logic [vwbp_pkg::CFG_W-1:0]     pk_width    = vwbp_pkg::CFG_RESET;
  logic [vwbp_pkg::BYTE_W-1:0]    pk_partial  = '0;
  logic [vwbp_pkg::FB_W-1:0]      pk_free     = vwbp_pkg::FB_EMPTY;

  packed_byte_t         expected_bytes[$];
  packed_byte_t         head_byte;

  rx_mode_t             rx_mode     = RX_ALWAYS;
  int                   stall_left  = 0;
  bit                   pace_on     = 1'b0;
  int                   burst_left  = 0;

  int                   fail_count     = 0;
  int                   cycle_count    = 0;
  int                   items_sent     = 0;
  int                   streams_sent   = 0;
  int                   bytes_checked  = 0;
  int                   width_writes   = 0;

  variable_width_bit_packer_top dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run; a hung packer ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
               expected_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive the receiver ready line per the selected stall pattern.
  always @(posedge clk) begin
    case (rx_mode)
      RX_ALWAYS: begin
        m_tready <= 1'b1;
      end
      RX_RANDOM: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
        end
      end
    endcase
  end

  // Compare every output transaction against the oldest predicted byte.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %02h final_byte %0b", m_tdata, m_tlast);
        fail_count++;
      end else begin
        head_byte = expected_bytes.pop_front();
        bytes_checked++;
        if (m_tdata !== head_byte.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", head_byte.data, m_tdata);
          fail_count++;
        end
        if (m_tlast !== head_byte.last_flag) begin
          $error("final_byte mismatch: expected %0b, actual %0b",
                 head_byte.last_flag, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Predict the bytes that one accepted value completes.
  function automatic void pack_value(input logic [vwbp_pkg::VALUE_W-1:0] value,
                                     input logic last);
    int unsigned                 w;
    int unsigned                 fb;
    int                          n;
    logic [63:0]                 v;
    logic [vwbp_pkg::BYTE_W-1:0] out_data[5];
    logic                        out_flag[5];
    packed_byte_t                pb;
    w = pk_width;
    if (w < 1) w = 1;
    if (w > vwbp_pkg::MAX_WIDTH) w = vwbp_pkg::MAX_WIDTH;
    if (w > vwbp_pkg::VALUE_W) w = vwbp_pkg::VALUE_W;
    fb = pk_free;
    if (fb < 1 || fb > vwbp_pkg::BYTE_W) fb = vwbp_pkg::BYTE_W;
    n = 0;
    v = {32'b0, value} & ((64'd1 << w) - 64'd1);
    // Fill the free low bits of the current byte; each full byte goes out.
    while (w >= fb) begin
      out_data[n] = pk_partial | vwbp_pkg::BYTE_W'(v & ((64'd1 << fb) - 64'd1));
      out_flag[n] = 1'b0;
      n++;
      v  = v >> fb;
      w  = w - fb;
      fb = vwbp_pkg::BYTE_W;
      pk_partial = '0;
    end
    // Park the leftover bits at the top of the free part.
    if (w != 0) begin
      pk_partial = pk_partial | vwbp_pkg::BYTE_W'(v << (fb - w));
      fb = fb - w;
    end
    if (last) begin
      if (fb < vwbp_pkg::BYTE_W) begin
        out_data[n] = pk_partial;
        out_flag[n] = 1'b1;
        n++;
      end else if (n > 0) begin
        out_flag[n-1] = 1'b1;
      end
      pk_partial = '0;
      fb = vwbp_pkg::BYTE_W;
    end
    pk_free = vwbp_pkg::FB_W'(fb);
    for (int i = 0; i < n; i++) begin
      pb.data      = out_data[i];
      pb.last_flag = out_flag[i];
      expected_bytes.insert(expected_bytes.size(), pb);
    end
  endfunction

  // Offer one value and hold it until the packer takes it.
  task automatic send_value(input logic [vwbp_pkg::VALUE_W-1:0] value, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pack_value(value, last);
    items_sent++;
    if (last) streams_sent++;
  endtask

  // Insert a random gap at the end of each sender burst.
  task automatic pace();
    if (pace_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // Hold the sender until every predicted byte is out, then let the
  // pipeline settle in case values without output are still in flight.
  task automatic drain_expected();
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [vwbp_pkg::CFG_W-1:0] w);
    drain_expected();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pk_width = w;
    width_writes++;
  endtask

  // Reset width of 8: one byte per value, upper bits dropped.
  task automatic test_default_width();
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h0000_00FF, 1'b0);
    send_value(32'hFFFF_FF5A, 1'b1);
  endtask

  // Full 32-bit values: four bytes each, final flag on the last one.
  task automatic test_full_width();
    write_width(vwbp_pkg::CFG_W'(32));
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h8000_0001, 1'b1);
  endtask

  // Width 0 acts as 1 bit; the stream ends on a partial byte.
  task automatic test_zero_width();
    write_width(vwbp_pkg::CFG_W'(0));
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hFFFF_FFFE, 1'b0);
    send_value(32'h0000_0001, 1'b1);
  endtask

  // Widths beyond 32 saturate to 32.
  task automatic test_oversized_width();
    write_width(vwbp_pkg::CFG_W'(63));
    send_value(32'hDEAD_BEEF, 1'b0);
    send_value(32'h0F0F_0F0F, 1'b1);
  endtask

  // Values straddling byte borders, last on an empty byte, and a wide value
  // that starts mid-byte and yields five bytes.
  task automatic test_straddle();
    write_width(vwbp_pkg::CFG_W'(5));
    send_value(32'h0000_001F, 1'b0);
    send_value(32'h0000_0015, 1'b0);
    send_value(32'h0000_000A, 1'b0);
    send_value(32'hFFFF_FFFB, 1'b1);
    write_width(vwbp_pkg::CFG_W'(4));
    send_value(32'h0000_000A, 1'b0);
    send_value(32'h0000_0005, 1'b1);
    write_width(vwbp_pkg::CFG_W'(3));
    send_value(32'h0000_0005, 1'b0);
    write_width(vwbp_pkg::CFG_W'(32));
    send_value(32'hFFFF_FFFF, 1'b1);
  endtask

  // Random phases: random width, random stall pattern, random stream lengths.
  task automatic test_random_streams();
    int                           start_items;
    int                           phase_len;
    int                           phase_num;
    logic [vwbp_pkg::CFG_W-1:0]   w;
    logic [vwbp_pkg::VALUE_W-1:0] value;
    logic                         last;
    start_items = items_sent;
    phase_num   = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = vwbp_pkg::CFG_W'(0);
        1: w = vwbp_pkg::CFG_W'(1);
        2: w = vwbp_pkg::CFG_W'(7);
        3: w = vwbp_pkg::CFG_W'(8);
        4: w = vwbp_pkg::CFG_W'(9);
        5: w = vwbp_pkg::CFG_W'(31);
        6: w = vwbp_pkg::CFG_W'(32);
        7: w = vwbp_pkg::CFG_W'(63);
        default: w = vwbp_pkg::CFG_W'($urandom_range(0, 63));
      endcase
      write_width(w);
      rx_mode    = rx_mode_t'($urandom_range(0, 2));
      pace_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(0, 12);
      phase_len  = $urandom_range(20, 40);
      for (int i = 0; i < phase_len; i++) begin
        case ($urandom_range(0, 9))
          0: value = '0;
          1: value = '1;
          default: value = $urandom;
        endcase
        last = ($urandom_range(0, 7) == 0) ||
               ((i == phase_len - 1) && ($urandom_range(0, 1) == 1));
        send_value(value, last);
        // Wait for the output to catch up mid first phase and at random times.
        if ((phase_num == 0 && i == phase_len / 2) || $urandom_range(0, 99) == 0) begin
          drain_expected();
        end else begin
          pace();
        end
      end
      phase_num++;
    end
    rx_mode = RX_ALWAYS;
    pace_on = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_width();
    test_full_width();
    test_zero_width();
    test_oversized_width();
    test_straddle();
    test_random_streams();
    drain_expected();
    $display("packed %0d values in %0d streams over %0d width writes", items_sent,
             streams_sent, width_writes);
    $display("checked %0d output bytes under mixed sender gaps and receiver stalls",
             bytes_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vwbp_pkg.sv
rtl/vwbp_front.sv
rtl/vwbp_fifo.sv
rtl/vwbp_back.sv
rtl/variable_width_bit_packer_top.sv
sim/tb.sv
